[rtl/core/fdtc_pkg.sv]
// ---------------------------------------------------------------------------
// fdtc_pkg
// shared types and constants of the fan duty temperature controller
// ---------------------------------------------------------------------------
package fdtc_pkg;

    localparam int DUTY_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int RAW_W       = 16;
    localparam int TEMP_W      = 10;  // temperatures and errors in tenths
    localparam int SUM_W       = 20;
    localparam int DIFF_W      = 11;
    localparam int GAIN_W      = 8;
    localparam int THR_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int ACC_W       = 32;
    localparam int DVD_W       = 14;  // linear ramp numerator, hundredths
    localparam int DVS_W       = 8;   // twice the threshold span
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    localparam int PWM_PERIOD_DEF = 100;

    // reset values of the configuration registers
    localparam logic             MODE_RST   = 1'b0;
    localparam logic [THR_W-1:0] LOW_RST    = 7'd30;
    localparam logic [THR_W-1:0] HIGH_RST   = 7'd40;
    localparam logic [TEMP_W-1:0] GOAL_RST  = 10'd250;
    localparam logic [GAIN_W-1:0] GAIN_P_RST = 8'd50;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 8'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 8'd20;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_MID = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_OFF = 7'd0;

    localparam logic [ACC_W-1:0] PID_BIAS  = 32'd500;
    localparam logic [ACC_W-1:0] PID_FULL  = 32'd1000;

    // x/10 for x < 100 as (x*205) >> 11
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int          DIV10_SHIFT = 11;
    // u/10 for u < 1000 as (u*6554) >> 16
    localparam logic [12:0] RECIP10_MUL   = 13'd6554;
    localparam int          RECIP10_SHIFT = 16;

    // sixteenths to hundredths: frac*625/100 = (frac*25) >> 2
    localparam logic [4:0] FRAC_MUL = 5'd25;

    localparam logic [3:0] NEG_NIBBLE = 4'hF;
    localparam logic [6:0] HUNDRED    = 7'd100;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic MODE_LINEAR = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_LOW    = 3'd1,
        CFG_HIGH   = 3'd2,
        CFG_GOAL   = 3'd3,
        CFG_GAIN_P = 3'd4,
        CFG_GAIN_I = 3'd5,
        CFG_GAIN_D = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } term_t;

endpackage

[rtl/core/fan_duty_temperature_controller_top.sv]
// ---------------------------------------------------------------------------
// fan_duty_temperature_controller_top
// sensor word to decimal digits, linear or pid fan duty, software pwm
// ---------------------------------------------------------------------------
// a tick goes straight to the output state; a linear sample passes through the
// ramp divider unless outside the thresholds, a pid sample through the error,
// sum, diff and multiply states unless below the goal; one item in flight, the
// next item is taken in the cycle after the result is loaded into the output
// register, and a full output register holds the sequencer until it drains;
// the single 32-bit adder runs 14 divide steps for the ramp and 24 shift-add steps for the three pid products
// rst_n clears state, pwm and history; registers return to their defaults
module fan_duty_temperature_controller_top #(
    parameter int PWM_PERIOD = fdtc_pkg::PWM_PERIOD_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fdtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdtc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // raw_reading [15:0], restart [16], zero [23:17]
    input  logic [fdtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // duty [6:0], motor_on [7], negative [8], digit_hundreds [9],
    // digit_tens [13:10], digit_units [17:14], digit_tenths [21:18],
    // digit_hundredths [25:22], zero [31:26]
    output logic [fdtc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fdtc_pkg::*;

    localparam int PHASE_W = $clog2(PWM_PERIOD + 1);
    localparam int CMP_W   = (PHASE_W > DUTY_W) ? PHASE_W : DUTY_W;
    localparam int CNT_W   = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3 * GAIN_W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LIN, S_DIV, S_LINQ, S_ERR, S_SUM, S_DIFF, S_MUL, S_PIDQ, S_OUT
    } state_t;

    // configuration
    logic               mode_reg;
    logic [THR_W-1:0]   low_reg;
    logic [THR_W-1:0]   high_reg;
    logic [TEMP_W-1:0]  goal_reg;
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RST;
            low_reg    <= LOW_RST;
            high_reg   <= HIGH_RST;
            goal_reg   <= GOAL_RST;
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_LOW:    low_reg    <= cfg_data[THR_W-1:0];
                CFG_HIGH:   high_reg   <= cfg_data[THR_W-1:0];
                CFG_GOAL:   goal_reg   <= cfg_data[TEMP_W-1:0];
                CFG_GAIN_P: gain_p_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: gain_i_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: gain_d_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TEMP_W-1:0]    last_err_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic                 drive_reg;
    logic [TEMP_W-1:0]    err_reg;
    logic [DIFF_W-1:0]    diff_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic                 neg_reg;
    logic                 hun_reg;
    logic [DIGIT_W-1:0]   tens_reg;
    logic [DIGIT_W-1:0]   units_reg;
    logic [DIGIT_W-1:0]   tth_reg;
    logic [DIGIT_W-1:0]   hth_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // ---- digit split of the incoming sensor word
    logic [RAW_W-1:0]   raw;
    logic               in_neg;
    logic [RAW_W-1:0]   mag;
    logic [6:0]         whole;
    logic               in_hun;
    logic [6:0]         below_hun;
    logic [14:0]        tens_prod;
    logic [DIGIT_W-1:0] in_tens;
    logic [DIGIT_W-1:0] in_units;
    logic [8:0]         frac_prod;
    logic [6:0]         frac_hth;
    logic [14:0]        tth_prod;
    logic [DIGIT_W-1:0] in_tth;
    logic [DIGIT_W-1:0] in_hth;

    always_comb
    begin
        raw       = s_tdata[RAW_W-1:0];
        in_neg    = (raw[RAW_W-1 -: 4] == NEG_NIBBLE);
        mag       = in_neg ? (~raw + 16'd1) : raw;
        whole     = mag[10:4];
        in_hun    = (whole >= HUNDRED);
        below_hun = in_hun ? (whole - HUNDRED) : whole;
        tens_prod = 15'(below_hun) * 15'(DIV10_MUL);
        in_tens   = tens_prod[DIV10_SHIFT +: DIGIT_W];
        in_units  = DIGIT_W'(below_hun - 7'(in_tens) * 7'd10);
        frac_prod = 9'(mag[3:0]) * 9'(FRAC_MUL);
        frac_hth  = frac_prod[8:2];
        tth_prod  = 15'(frac_hth) * 15'(DIV10_MUL);
        in_tth    = tth_prod[DIV10_SHIFT +: DIGIT_W];
        in_hth    = DIGIT_W'(frac_hth - 7'(in_tth) * 7'd10);
    end

    // ---- temperatures from the held digits
    logic [THR_W-1:0]  temp_whole;
    logic [DVD_W-1:0]  temp_hth;
    logic [TEMP_W-1:0] temp_tenths;
    logic [DVD_W-1:0]  low_hth;

    always_comb
    begin
        temp_whole  = 7'(tens_reg) * 7'd10 + 7'(units_reg);
        temp_hth    = 14'(tens_reg) * 14'd1000 + 14'(units_reg) * 14'd100
                    + 14'(tth_reg) * 14'd10 + 14'(hth_reg);
        temp_tenths = 10'(tens_reg) * 10'd100 + 10'(units_reg) * 10'd10
                    + 10'(tth_reg);
        low_hth     = 14'(low_reg) * 14'd100;
    end

    // ---- shared adder
    logic [ACC_W-1:0]  add_a;
    logic [ACC_W-1:0]  add_b;
    logic              add_sub;
    logic [ACC_W-1:0]  add_sum;
    logic [DVS_W:0]    div_shift;
    logic [ACC_W-1:0]  mcand;
    logic [GAIN_W-1:0] gain_sel;
    logic [2:0]        bit_sel;

    always_comb
    begin
        div_shift = {rem_reg, dvd_reg[DVD_W-1]};
        bit_sel   = cnt_reg[2:0];
        case (term_t'(cnt_reg[4:3]))
            TERM_P:
            begin
                gain_sel = gain_p_reg;
                mcand    = ACC_W'(err_reg);
            end
            TERM_I:
            begin
                gain_sel = gain_i_reg;
                mcand    = ACC_W'(sum_reg);
            end
            TERM_D:
            begin
                gain_sel = gain_d_reg;
                mcand    = {{(ACC_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
            end
            default:
            begin
                gain_sel = '0;
                mcand    = '0;
            end
        endcase

        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_LIN:
            begin
                add_a   = ACC_W'(temp_hth);
                add_b   = ACC_W'(low_hth);
                add_sub = 1'b1;
            end
            S_DIV:
            begin
                add_a   = ACC_W'(div_shift);
                add_b   = ACC_W'(dvs_reg);
                add_sub = 1'b1;
            end
            S_ERR:
            begin
                add_a   = ACC_W'(temp_tenths);
                add_b   = ACC_W'(goal_reg);
                add_sub = 1'b1;
            end
            S_SUM:
            begin
                add_a = ACC_W'(sum_reg);
                add_b = ACC_W'(err_reg);
            end
            S_DIFF:
            begin
                add_a   = ACC_W'(err_reg);
                add_b   = ACC_W'(last_err_reg);
                add_sub = 1'b1;
            end
            S_MUL:
            begin
                add_a = acc_reg;
                add_b = gain_sel[bit_sel] ? (mcand << bit_sel) : '0;
            end
            default: ;
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);
    end

    // ---- pid output scaling and pwm compare
    logic [22:0] recip_prod;
    logic        acc_full;
    logic        acc_low;
    logic        pwm_on;
    logic        pwm_run;

    always_comb
    begin
        recip_prod = 23'(acc_reg[9:0]) * 23'(RECIP10_MUL);
        acc_full   = !acc_reg[ACC_W-1] && (acc_reg >= PID_FULL);
        acc_low    = acc_reg[ACC_W-1] || (acc_reg == '0);
        pwm_on     = CMP_W'(phase_reg) < CMP_W'(duty_reg);
        pwm_run    = phase_reg < PHASE_W'(PWM_PERIOD);
    end

    // ---- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            last_err_reg <= '0;
            sum_reg      <= '0;
            duty_reg     <= '0;
            phase_reg    <= '0;
            drive_reg    <= 1'b0;
            err_reg      <= '0;
            diff_reg     <= '0;
            acc_reg      <= '0;
            dvd_reg      <= '0;
            dvs_reg      <= '0;
            rem_reg      <= '0;
            neg_reg      <= 1'b0;
            hun_reg      <= 1'b0;
            tens_reg     <= '0;
            units_reg    <= '0;
            tth_reg      <= '0;
            hth_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            // the output state reloads the register itself
            if (m_tready && (state_reg != S_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser == FUNC_TICK)
                        begin
                            neg_reg   <= 1'b0;
                            hun_reg   <= 1'b0;
                            tens_reg  <= '0;
                            units_reg <= '0;
                            tth_reg   <= '0;
                            hth_reg   <= '0;
                            if (pwm_on)
                            begin
                                drive_reg <= 1'b1;
                                phase_reg <= phase_reg + PHASE_W'(1);
                            end
                            else if (pwm_run)
                            begin
                                drive_reg <= 1'b0;
                                phase_reg <= phase_reg + PHASE_W'(1);
                            end
                            else
                            begin
                                phase_reg <= '0;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            neg_reg   <= in_neg;
                            hun_reg   <= in_hun;
                            tens_reg  <= in_tens;
                            units_reg <= in_units;
                            tth_reg   <= in_tth;
                            hth_reg   <= in_hth;
                            if (s_tdata[RAW_W])
                            begin
                                last_err_reg <= '0;
                                sum_reg      <= '0;
                            end
                            state_reg <= (mode_reg == MODE_LINEAR) ? S_LIN : S_ERR;
                        end
                    end
                end
                S_LIN:
                begin
                    if (temp_whole >= high_reg)
                    begin
                        duty_reg  <= DUTY_MAX;
                        state_reg <= S_OUT;
                    end
                    else if (temp_whole < low_reg)
                    begin
                        duty_reg  <= DUTY_OFF;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        dvd_reg   <= add_sum[DVD_W-1:0];
                        dvs_reg   <= {high_reg - low_reg, 1'b0};
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring step, quotient bits shift in from the right
                    if (!add_sum[ACC_W-1])
                    begin
                        rem_reg <= add_sum[DVS_W-1:0];
                        dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_shift[DVS_W-1:0];
                        dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_LINQ;
                    end
                end
                S_LINQ:
                begin
                    duty_reg  <= dvd_reg[DUTY_W-1:0] + DUTY_MID;
                    state_reg <= S_OUT;
                end
                S_ERR:
                begin
                    if (add_sum[ACC_W-1])
                    begin
                        duty_reg  <= DUTY_OFF;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        err_reg   <= add_sum[TEMP_W-1:0];
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    sum_reg   <= (|add_sum[ACC_W-1:SUM_W]) ? '1 : add_sum[SUM_W-1:0];
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    diff_reg     <= add_sum[DIFF_W-1:0];
                    last_err_reg <= err_reg;
                    acc_reg      <= PID_BIAS;
                    cnt_reg      <= '0;
                    state_reg    <= S_MUL;
                end
                S_MUL:
                begin
                    acc_reg <= add_sum;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= S_PIDQ;
                    end
                end
                S_PIDQ:
                begin
                    if (acc_full)
                    begin
                        duty_reg <= DUTY_MAX;
                    end
                    else if (acc_low)
                    begin
                        duty_reg <= DUTY_MID;
                    end
                    else
                    begin
                        duty_reg <= recip_prod[RECIP10_SHIFT +: DUTY_W];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, hth_reg, tth_reg, units_reg, tens_reg,
                                        hun_reg, neg_reg, drive_reg, duty_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_MAX)
        else $error("duty above full scale");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_W'(PWM_PERIOD))
        else $error("pwm phase beyond period");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

    a_drive_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(drive_reg) |-> $past(s_tvalid && s_tready && s_tuser))
        else $error("drive changed without a tick item");
`endif

endmodule
